@@ design/unix_seconds_to_calendar_date_defines.svh @@
// Assertion macros used by the calendar date converter checker
`ifndef UNIX_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH
`define UNIX_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH

// Condition must hold at every clock edge out of reset
`define UCD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define UCD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define UCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ucd_pkg.sv @@
// Package: widths, reciprocal constants and small tables of the calendar date converter
`timescale 1ns / 1ps

package ucd_pkg;

	localparam int NSTG = 14;
	localparam int TDATA_IN_W = 32;
	localparam int TDATA_OUT_W = 48;

	localparam logic [31:0] M_DIV60_W32 = 32'h8888_8889;
	localparam logic [26:0] M_DIV60_W27 = 27'd71582789;
	localparam logic [24:0] M_DIV24 = 25'd22369622;
	localparam logic [26:0] M_DIV7305 = 27'd75257470;
	localparam logic [29:0] M_DIV30601K = 30'd561416000;
	localparam logic [12:0] M_DIV100 = 13'd5243;
	localparam logic [10:0] M_DIV7 = 11'd1171;

	localparam logic [5:0] SECS_PER_MIN = 6'd60;
	localparam logic [5:0] MINS_PER_HOUR = 6'd60;
	localparam logic [4:0] HOURS_PER_DAY = 5'd24;

	localparam logic [21:0] B_BASE = 22'd2442125;
	localparam logic [15:0] A_STEP_DAY = 16'd47541;
	localparam logic [4:0] X_MUL = 5'd20;
	localparam logic [25:0] X_SUB = 26'd2442;
	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
	localparam logic [4:0] DAYS_PER_MONTH = 5'd30;
	localparam int YEAR_OFS_LO = 4716;
	localparam int YEAR_OFS_HI = 4715;
	localparam logic [3:0] LAST_LATE_MONTH = 4'd13;
	localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
	localparam logic [3:0] LAST_EARLY_MONTH = 4'd2;
	localparam logic [6:0] YEARS_PER_CENT = 7'd100;
	localparam logic [9:0] CENT_WEIGHT = 10'd5;
	localparam logic [9:0] WEEK_OFS = 10'd5;
	localparam logic [2:0] DAYS_PER_WEEK = 3'd7;

	// floor(601 * e / 1000)
	function automatic logic [3:0] frac601(input logic [3:0] e);
		logic [3:0] r;
		unique case (e)
			4'd0, 4'd1: r = 4'd0;
			4'd2, 4'd3: r = 4'd1;
			4'd4: r = 4'd2;
			4'd5, 4'd6: r = 4'd3;
			4'd7, 4'd8: r = 4'd4;
			4'd9: r = 4'd5;
			4'd10, 4'd11: r = 4'd6;
			4'd12, 4'd13: r = 4'd7;
			4'd14: r = 4'd8;
			default: r = 4'd9;
		endcase
		return r;
	endfunction

	// floor(26 * (m + 1) / 10)
	function automatic logic [5:0] month_term(input logic [3:0] m);
		logic [5:0] r;
		unique case (m)
			4'd0: r = 6'd2;
			4'd1: r = 6'd5;
			4'd2: r = 6'd7;
			4'd3: r = 6'd10;
			4'd4: r = 6'd13;
			4'd5: r = 6'd15;
			4'd6: r = 6'd18;
			4'd7: r = 6'd20;
			4'd8: r = 6'd23;
			4'd9: r = 6'd26;
			4'd10: r = 6'd28;
			4'd11: r = 6'd31;
			4'd12: r = 6'd33;
			4'd13: r = 6'd36;
			4'd14: r = 6'd39;
			default: r = 6'd41;
		endcase
		return r;
	endfunction

endpackage

@@ design/unix_seconds_to_calendar_date.sv @@
// Top level: pipelined conversion of Unix seconds to calendar date, time and weekday
//
// Usage:
//   s_tdata carries one 32-bit unsigned count of seconds since 1970-01-01 00:00:00.
//   m_tdata returns the date and time of that instant, one word per input word,
//   in input order. Both channels move a word when tvalid and tready are high.
//   Throughput is one word per cycle while m_tready is high: the 14-stage
//   pipeline then takes a new word every cycle, each stage holding at most one
//   reciprocal multiply plus short constant arithmetic.
//   When m_tready is low the output word holds; earlier stages keep filling
//   empty slots, and s_tready falls only once every stage holds a word.
//   Reset clears all stage valid bits; words in flight are dropped.
//   The whole 32-bit input range is valid and every word gives a result.
`timescale 1ns / 1ps

module unix_seconds_to_calendar_date (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [31:0] unix_seconds
	input  logic [ucd_pkg::TDATA_IN_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [11:0] year, [15:12] month, [20:16] day, [25:21] hours, [31:26] minutes,
	// [37:32] secs, [40:38] weekday, [47:41] zero
	output logic [ucd_pkg::TDATA_OUT_W-1:0]   m_tdata
);

	logic [ucd_pkg::NSTG:1] vld_q;
	logic [ucd_pkg::NSTG:1] vld_in;
	logic [ucd_pkg::NSTG:1] adv;

	logic [63:0] p1;
	logic [53:0] p2;
	logic [45:0] p3;
	logic [52:0] p6;
	logic [38:0] p8;
	logic [24:0] p10;
	logic [20:0] p13;

	logic [5:0]  sec_n, min_n;
	logic [4:0]  hr_n;
	logic [21:0] b_n;
	logic [25:0] x_n;
	logic [8:0]  d_n;
	logic [4:0]  f_n;
	logic [11:0] year_n, yz_n;
	logic [3:0]  mon_n, mz_n;
	logic [6:0]  yoc_n;
	logic [9:0]  hp_n, h5_n;
	logic [2:0]  wd_n;

	// stage registers
	logic [5:0]  t_s1;
	logic [26:0] q1_s1;
	logic [5:0]  sec_s2, q1_s2;
	logic [20:0] q2_s2;
	logic [5:0]  sec_s3, min_s3;
	logic [4:0]  q2_s3;
	logic [15:0] q3_s3;
	logic [5:0]  sec_s4, min_s4;
	logic [4:0]  hr_s4;
	logic [21:0] b_s4;
	logic [5:0]  sec_s5, min_s5;
	logic [4:0]  hr_s5;
	logic [8:0]  b_s5;
	logic [25:0] x_s5;
	logic [5:0]  sec_s6, min_s6;
	logic [4:0]  hr_s6;
	logic [8:0]  b_s6;
	logic [12:0] c_s6;
	logic [5:0]  sec_s7, min_s7;
	logic [4:0]  hr_s7;
	logic [11:0] c_s7;
	logic [8:0]  d_s7;
	logic [5:0]  sec_s8, min_s8;
	logic [4:0]  hr_s8;
	logic [11:0] c_s8;
	logic [4:0]  d_s8;
	logic [3:0]  e_s8;
	logic [5:0]  sec_s9, min_s9;
	logic [4:0]  hr_s9, f_s9;
	logic [11:0] year_s9, yz_s9;
	logic [3:0]  mon_s9, mz_s9;
	logic [5:0]  sec_s10, min_s10, cent_s10;
	logic [4:0]  hr_s10, f_s10;
	logic [11:0] year_s10;
	logic [6:0]  yz_s10;
	logic [3:0]  mon_s10, mz_s10;
	logic [5:0]  sec_s11, min_s11;
	logic [4:0]  hr_s11, f_s11;
	logic [11:0] year_s11;
	logic [3:0]  mon_s11;
	logic [6:0]  yoc_s11;
	logic [9:0]  hp_s11;
	logic [5:0]  sec_s12, min_s12;
	logic [4:0]  hr_s12, f_s12;
	logic [11:0] year_s12;
	logic [3:0]  mon_s12;
	logic [9:0]  h5_s12;
	logic [5:0]  sec_s13, min_s13;
	logic [4:0]  hr_s13, f_s13;
	logic [11:0] year_s13;
	logic [3:0]  mon_s13;
	logic [2:0]  h5_s13;
	logic [7:0]  q7_s13;
	logic [5:0]  sec_s14, min_s14;
	logic [4:0]  hr_s14, f_s14;
	logic [11:0] year_s14;
	logic [3:0]  mon_s14;
	logic [2:0]  wd_s14;

	// advance a stage when it or any later stage has room
	genvar gk;
	generate
		for (gk = 1; gk <= ucd_pkg::NSTG; gk++) begin : g_adv
			assign adv[gk] = m_tready | ~(&vld_q[ucd_pkg::NSTG:gk]);
		end
	endgenerate

	assign vld_in = {vld_q[ucd_pkg::NSTG-1:1], s_tvalid};
	assign s_tready = adv[1];
	assign m_tvalid = vld_q[ucd_pkg::NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= ucd_pkg::NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	always_comb begin
		p1 = 64'(s_tdata[31:0]) * 64'(ucd_pkg::M_DIV60_W32);
		p2 = 54'(q1_s1) * 54'(ucd_pkg::M_DIV60_W27);
		sec_n = t_s1 - 6'(q1_s1[5:0] * ucd_pkg::SECS_PER_MIN);
		p3 = 46'(q2_s2) * 46'(ucd_pkg::M_DIV24);
		min_n = q1_s2 - 6'(q2_s2[5:0] * ucd_pkg::MINS_PER_HOUR);
		hr_n = q2_s3 - 5'(q3_s3[4:0] * ucd_pkg::HOURS_PER_DAY);
		b_n = 22'(q3_s3) + ucd_pkg::B_BASE + 22'(q3_s3 >= ucd_pkg::A_STEP_DAY);
		x_n = 26'(b_s4) * 26'(ucd_pkg::X_MUL) - ucd_pkg::X_SUB;
		p6 = 53'(x_s5) * 53'(ucd_pkg::M_DIV7305);
		d_n = b_s6 - 9'(c_s6[8:0] * ucd_pkg::DAYS_PER_YEAR) - c_s6[10:2];
		p8 = 39'(d_s7) * 39'(ucd_pkg::M_DIV30601K);
		f_n = d_s8 - 5'(5'(e_s8) * ucd_pkg::DAYS_PER_MONTH) - 5'(ucd_pkg::frac601(e_s8));
		if (e_s8 <= ucd_pkg::LAST_LATE_MONTH) begin
			year_n = c_s8 - 12'(ucd_pkg::YEAR_OFS_LO);
			mon_n = e_s8 - 4'd1;
		end else begin
			year_n = c_s8 - 12'(ucd_pkg::YEAR_OFS_HI);
			mon_n = e_s8 - ucd_pkg::LAST_LATE_MONTH;
		end
		if (mon_n <= ucd_pkg::LAST_EARLY_MONTH) begin
			yz_n = year_n - 12'd1;
			mz_n = mon_n + ucd_pkg::MONTHS_PER_YEAR;
		end else begin
			yz_n = year_n;
			mz_n = mon_n;
		end
		p10 = 25'(yz_s9) * 25'(ucd_pkg::M_DIV100);
		yoc_n = yz_s10 - 7'(7'(cent_s10) * ucd_pkg::YEARS_PER_CENT);
		hp_n = 10'(f_s10) + 10'(ucd_pkg::month_term(mz_s10))
			+ 10'(cent_s10) * ucd_pkg::CENT_WEIGHT + 10'(cent_s10[5:2]);
		h5_n = hp_s11 + 10'(yoc_s11) + 10'(yoc_s11[6:2]) + ucd_pkg::WEEK_OFS;
		p13 = 21'(h5_s12) * 21'(ucd_pkg::M_DIV7);
		wd_n = h5_s13 - 3'(q7_s13[2:0] * ucd_pkg::DAYS_PER_WEEK) + 3'd1;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			t_s1 <= s_tdata[5:0];
			q1_s1 <= p1[63:37];
		end
		if (adv[2]) begin
			sec_s2 <= sec_n;
			q1_s2 <= q1_s1[5:0];
			q2_s2 <= p2[52:32];
		end
		if (adv[3]) begin
			sec_s3 <= sec_s2;
			min_s3 <= min_n;
			q2_s3 <= q2_s2[4:0];
			q3_s3 <= p3[44:29];
		end
		if (adv[4]) begin
			sec_s4 <= sec_s3;
			min_s4 <= min_s3;
			hr_s4 <= hr_n;
			b_s4 <= b_n;
		end
		if (adv[5]) begin
			sec_s5 <= sec_s4;
			min_s5 <= min_s4;
			hr_s5 <= hr_s4;
			b_s5 <= b_s4[8:0];
			x_s5 <= x_n;
		end
		if (adv[6]) begin
			sec_s6 <= sec_s5;
			min_s6 <= min_s5;
			hr_s6 <= hr_s5;
			b_s6 <= b_s5;
			c_s6 <= p6[51:39];
		end
		if (adv[7]) begin
			sec_s7 <= sec_s6;
			min_s7 <= min_s6;
			hr_s7 <= hr_s6;
			c_s7 <= c_s6[11:0];
			d_s7 <= d_n;
		end
		if (adv[8]) begin
			sec_s8 <= sec_s7;
			min_s8 <= min_s7;
			hr_s8 <= hr_s7;
			c_s8 <= c_s7;
			d_s8 <= d_s7[4:0];
			e_s8 <= p8[37:34];
		end
		if (adv[9]) begin
			sec_s9 <= sec_s8;
			min_s9 <= min_s8;
			hr_s9 <= hr_s8;
			f_s9 <= f_n;
			year_s9 <= year_n;
			mon_s9 <= mon_n;
			yz_s9 <= yz_n;
			mz_s9 <= mz_n;
		end
		if (adv[10]) begin
			sec_s10 <= sec_s9;
			min_s10 <= min_s9;
			hr_s10 <= hr_s9;
			f_s10 <= f_s9;
			year_s10 <= year_s9;
			mon_s10 <= mon_s9;
			yz_s10 <= yz_s9[6:0];
			mz_s10 <= mz_s9;
			cent_s10 <= p10[24:19];
		end
		if (adv[11]) begin
			sec_s11 <= sec_s10;
			min_s11 <= min_s10;
			hr_s11 <= hr_s10;
			f_s11 <= f_s10;
			year_s11 <= year_s10;
			mon_s11 <= mon_s10;
			yoc_s11 <= yoc_n;
			hp_s11 <= hp_n;
		end
		if (adv[12]) begin
			sec_s12 <= sec_s11;
			min_s12 <= min_s11;
			hr_s12 <= hr_s11;
			f_s12 <= f_s11;
			year_s12 <= year_s11;
			mon_s12 <= mon_s11;
			h5_s12 <= h5_n;
		end
		if (adv[13]) begin
			sec_s13 <= sec_s12;
			min_s13 <= min_s12;
			hr_s13 <= hr_s12;
			f_s13 <= f_s12;
			year_s13 <= year_s12;
			mon_s13 <= mon_s12;
			h5_s13 <= h5_s12[2:0];
			q7_s13 <= p13[20:13];
		end
		if (adv[14]) begin
			sec_s14 <= sec_s13;
			min_s14 <= min_s13;
			hr_s14 <= hr_s13;
			f_s14 <= f_s13;
			year_s14 <= year_s13;
			mon_s14 <= mon_s13;
			wd_s14 <= wd_n;
		end
	end

	assign m_tdata = {7'd0, wd_s14, sec_s14, min_s14, hr_s14, f_s14, mon_s14, year_s14};

endmodule

@@ design/ucd_checker.sv @@
// Checker: port-level assertions for the calendar date converter, bound to the top level
`timescale 1ns / 1ps
`include "unix_seconds_to_calendar_date_defines.svh"

module ucd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [ucd_pkg::TDATA_IN_W-1:0]  s_tdata,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ucd_pkg::TDATA_OUT_W-1:0] m_tdata
);

	`UCD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
	`UCD_ASSERT_SAME(a_in_ready, !m_tvalid || m_tready, s_tready, "input stalled with room in the pipeline")
	`UCD_ASSERT_SAME(a_date_range, m_tvalid, (m_tdata[11:0] >= 12'd1970) && (m_tdata[11:0] <= 12'd2106) && (m_tdata[15:12] >= 4'd1) && (m_tdata[15:12] <= 4'd12) && (m_tdata[20:16] >= 5'd1), "date field out of range")
	`UCD_ASSERT_SAME(a_time_range, m_tvalid, (m_tdata[25:21] <= 5'd23) && (m_tdata[31:26] <= 6'd59) && (m_tdata[37:32] <= 6'd59) && (m_tdata[40:38] != 3'd0) && (m_tdata[47:41] == 7'd0), "time or weekday field out of range")

endmodule

bind unix_seconds_to_calendar_date ucd_checker u_ucd_checker (.*);
